// ===== rtl/wtrb_pkg.sv =====
`default_nettype none
package wtrb_pkg;

  localparam int DEPTH       = 1024;
  localparam int MAX_BURST   = 64;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int BURST_W     = 7;
  localparam int TS_W        = 32;
  localparam int PL_W        = 64;
  localparam int OFFS_W      = 10;
  localparam int EVERY_W     = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_READ_OFFSET = 3'd1,
    OP_READ_WINDOW = 3'd2,
    OP_COUNT       = 3'd3,
    OP_CLEAR       = 3'd4
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [TS_W-1:0]     ts;
    logic [PL_W-1:0]     pl;
    logic [BURST_W-1:0]  maxo;
    logic [OFFS_W-1:0]   offs;
    logic [TS_W-1:0]     win;
    logic [EVERY_W-1:0]  every;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/wtrb_front.sv =====
`default_nettype none
module wtrb_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [wtrb_pkg::TS_W-1:0]   in_record_timestamp,
  input  wire logic [wtrb_pkg::PL_W-1:0]   in_record_payload,
  input  wire logic [6:0]                  in_max_out,
  input  wire logic [9:0]                  in_start_offset,
  input  wire logic [wtrb_pkg::TS_W-1:0]   in_time_window,
  input  wire logic [9:0]                  in_keep_every,
  input  wire wtrb_pkg::q_status_t         q_status,
  output logic                             q_push,
  output wtrb_pkg::cmd_t                   q_cmd
);

  logic           front_valid_r;
  logic           front_valid_nxt;
  wtrb_pkg::cmd_t cmd_r;
  wtrb_pkg::cmd_t cmd_nxt;
  logic           accept;
  logic           known_op;

  assign q_push   = front_valid_r && !q_status.full;
  assign in_stall = front_valid_r && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign q_cmd    = cmd_r;

  always_comb begin
    unique case (wtrb_pkg::op_t'(in_operation))
      wtrb_pkg::OP_APPEND,
      wtrb_pkg::OP_READ_OFFSET,
      wtrb_pkg::OP_READ_WINDOW,
      wtrb_pkg::OP_COUNT,
      wtrb_pkg::OP_CLEAR: known_op = 1'b1;
      default:            known_op = 1'b0;
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    cmd_nxt.op    = wtrb_pkg::op_t'(in_operation);
    cmd_nxt.ts    = in_record_timestamp;
    cmd_nxt.pl    = in_record_payload;
    cmd_nxt.offs  = in_start_offset;
    cmd_nxt.win   = in_time_window;
    cmd_nxt.every = in_keep_every;
    // saturate burst length
    if (in_max_out > wtrb_pkg::BURST_W'(wtrb_pkg::MAX_BURST)) begin
      cmd_nxt.maxo = wtrb_pkg::BURST_W'(wtrb_pkg::MAX_BURST);
    end else begin
      cmd_nxt.maxo = in_max_out;
    end
  end

  always_comb begin
    front_valid_nxt = front_valid_r && !q_push;
    if (accept && known_op) begin
      front_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && known_op) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wtrb_cmd_queue.sv =====
`default_nettype none
module wtrb_cmd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire wtrb_pkg::cmd_t       push_cmd,
  input  wire logic                 pop,
  output wtrb_pkg::cmd_t            pop_cmd,
  output wtrb_pkg::q_status_t       status
);

  wtrb_pkg::cmd_t                    q_mem_r [wtrb_pkg::QUEUE_DEPTH];
  logic [wtrb_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [wtrb_pkg::QPTR_W-1:0]       wr_ptr_nxt;
  logic [wtrb_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [wtrb_pkg::QPTR_W-1:0]       rd_ptr_nxt;
  logic [wtrb_pkg::QCNT_W-1:0]       cnt_r;
  logic [wtrb_pkg::QCNT_W-1:0]       cnt_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign status.full  = (cnt_r == wtrb_pkg::QCNT_W'(wtrb_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == wtrb_pkg::QPTR_W'(wtrb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == wtrb_pkg::QPTR_W'(wtrb_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wtrb_engine.sv =====
`default_nettype none
module wtrb_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire wtrb_pkg::cmd_t              cmd,
  input  wire logic                        cmd_empty,
  output logic                             cmd_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_valid_res,
  output logic [wtrb_pkg::TS_W-1:0]        out_timestamp,
  output logic [wtrb_pkg::PL_W-1:0]        out_payload,
  output logic [wtrb_pkg::CNT_W-1:0]       out_tally,
  output logic                             out_last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  logic [wtrb_pkg::TS_W-1:0] time_mem [wtrb_pkg::DEPTH];
  logic [wtrb_pkg::PL_W-1:0] pay_mem  [wtrb_pkg::DEPTH];

  state_t                          state_r, state_nxt;
  logic [wtrb_pkg::ADDR_W-1:0]     head_r, head_nxt;
  logic [wtrb_pkg::CNT_W-1:0]      fill_r, fill_nxt;
  logic [wtrb_pkg::TS_W-1:0]       newest_r, newest_nxt;
  wtrb_pkg::op_t                   op_r, op_nxt;
  logic [wtrb_pkg::BURST_W-1:0]    maxo_r, maxo_nxt;
  logic [wtrb_pkg::EVERY_W-1:0]    every_r, every_nxt;
  logic [wtrb_pkg::TS_W-1:0]       cut_r, cut_nxt;
  logic [wtrb_pkg::CNT_W-1:0]      age_r, age_nxt;
  logic [wtrb_pkg::BURST_W-1:0]    n_r, n_nxt;
  logic [wtrb_pkg::EVERY_W-1:0]    skip_r, skip_nxt;
  logic [wtrb_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [wtrb_pkg::ADDR_W-1:0]     oldest_r, oldest_nxt;
  logic                            pend_valid_r, pend_valid_nxt;
  logic [wtrb_pkg::TS_W-1:0]       pend_ts_r;
  logic [wtrb_pkg::PL_W-1:0]       pend_pl_r;
  logic [wtrb_pkg::TS_W-1:0]       rd_ts_r;
  logic [wtrb_pkg::PL_W-1:0]       rd_pl_r;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_valid_res_r, out_valid_res_nxt;
  logic [wtrb_pkg::TS_W-1:0]       out_ts_r, out_ts_nxt;
  logic [wtrb_pkg::PL_W-1:0]       out_pl_r, out_pl_nxt;
  logic [wtrb_pkg::CNT_W-1:0]      out_tally_r, out_tally_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;
  logic                            out_ld;
  logic                            wr_en;
  logic                            rd_en;
  logic                            pend_ld;
  logic [wtrb_pkg::ADDR_W-1:0]     rd_addr;
  logic                            keep;
  logic                            emit;
  logic [wtrb_pkg::TS_W-1:0]       cut_calc;
  logic [wtrb_pkg::EVERY_W:0]      skip_inc;

  assign out_free      = !out_valid_r || !out_stall;
  assign rd_en         = (state_r == S_RD);
  assign rd_addr       = oldest_r + age_r[wtrb_pkg::ADDR_W-1:0];
  assign keep          = !(rd_ts_r < cut_r);
  assign emit          = (op_r == wtrb_pkg::OP_READ_OFFSET) ||
                         ((op_r == wtrb_pkg::OP_READ_WINDOW) && keep && (skip_r == '0));
  assign skip_inc      = {1'b0, skip_r} + 1'b1;
  assign cut_calc      = ((cmd.win != '0) && (newest_r > cmd.win)) ? newest_r - cmd.win : '0;

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_valid_res_r;
  assign out_timestamp = out_ts_r;
  assign out_payload   = out_pl_r;
  assign out_tally     = out_tally_r;
  assign out_last      = out_last_r;

  always_comb begin
    state_nxt         = state_r;
    head_nxt          = head_r;
    fill_nxt          = fill_r;
    newest_nxt        = newest_r;
    op_nxt            = op_r;
    maxo_nxt          = maxo_r;
    every_nxt         = every_r;
    cut_nxt           = cut_r;
    age_nxt           = age_r;
    n_nxt             = n_r;
    skip_nxt          = skip_r;
    cnt_nxt           = cnt_r;
    oldest_nxt        = oldest_r;
    pend_valid_nxt    = pend_valid_r;
    pend_ld           = 1'b0;
    cmd_pop           = 1'b0;
    wr_en             = 1'b0;
    out_ld            = 1'b0;
    out_valid_res_nxt = out_valid_res_r;
    out_ts_nxt        = out_ts_r;
    out_pl_nxt        = out_pl_r;
    out_tally_nxt     = out_tally_r;
    out_last_nxt      = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop        = 1'b1;
          op_nxt         = cmd.op;
          maxo_nxt       = cmd.maxo;
          every_nxt      = cmd.every;
          cut_nxt        = cut_calc;
          oldest_nxt     = head_r - fill_r[wtrb_pkg::ADDR_W-1:0];
          n_nxt          = '0;
          skip_nxt       = '0;
          cnt_nxt        = '0;
          pend_valid_nxt = 1'b0;
          age_nxt        = '0;
          unique case (cmd.op)
            wtrb_pkg::OP_APPEND: begin
              wr_en      = 1'b1;
              head_nxt   = head_r + 1'b1;
              newest_nxt = cmd.ts;
              if (fill_r < wtrb_pkg::CNT_W'(wtrb_pkg::DEPTH)) begin
                fill_nxt = fill_r + 1'b1;
              end
            end
            wtrb_pkg::OP_CLEAR: begin
              head_nxt = '0;
              fill_nxt = '0;
            end
            wtrb_pkg::OP_READ_OFFSET: begin
              age_nxt = wtrb_pkg::CNT_W'(cmd.offs);
              if ((cmd.maxo == '0) || (wtrb_pkg::CNT_W'(cmd.offs) >= fill_r)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            wtrb_pkg::OP_READ_WINDOW: begin
              if ((cmd.maxo == '0) || (cmd.every == '0) || (fill_r == '0)) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            wtrb_pkg::OP_COUNT: begin
              state_nxt = (fill_r == '0) ? S_DONE : S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!(emit && pend_valid_r && !out_free)) begin
          if (emit) begin
            if (pend_valid_r) begin
              out_ld            = 1'b1;
              out_valid_res_nxt = 1'b1;
              out_ts_nxt        = pend_ts_r;
              out_pl_nxt        = pend_pl_r;
              out_tally_nxt     = fill_r;
              out_last_nxt      = 1'b0;
            end
            pend_ld        = 1'b1;
            pend_valid_nxt = 1'b1;
            n_nxt          = n_r + 1'b1;
          end
          if ((op_r == wtrb_pkg::OP_READ_WINDOW) && keep) begin
            skip_nxt = (skip_inc == {1'b0, every_r}) ? '0 : skip_inc[wtrb_pkg::EVERY_W-1:0];
          end
          if ((op_r == wtrb_pkg::OP_COUNT) && keep) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          age_nxt = age_r + 1'b1;
          if ((age_r + 1'b1 == fill_r) || (emit && (n_r + 1'b1 == maxo_r))) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_ld         = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
          if (op_r == wtrb_pkg::OP_COUNT) begin
            out_valid_res_nxt = 1'b1;
            out_ts_nxt        = '0;
            out_pl_nxt        = '0;
            out_tally_nxt     = cnt_r;
          end else if (pend_valid_r) begin
            out_valid_res_nxt = 1'b1;
            out_ts_nxt        = pend_ts_r;
            out_pl_nxt        = pend_pl_r;
            out_tally_nxt     = fill_r;
          end else begin
            out_valid_res_nxt = 1'b0;
            out_ts_nxt        = '0;
            out_pl_nxt        = '0;
            out_tally_nxt     = fill_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      fill_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r        <= newest_nxt;
    op_r            <= op_nxt;
    maxo_r          <= maxo_nxt;
    every_r         <= every_nxt;
    cut_r           <= cut_nxt;
    age_r           <= age_nxt;
    n_r             <= n_nxt;
    skip_r          <= skip_nxt;
    cnt_r           <= cnt_nxt;
    oldest_r        <= oldest_nxt;
    out_valid_res_r <= out_valid_res_nxt;
    out_ts_r        <= out_ts_nxt;
    out_pl_r        <= out_pl_nxt;
    out_tally_r     <= out_tally_nxt;
    out_last_r      <= out_last_nxt;
    if (pend_ld) begin
      pend_ts_r <= rd_ts_r;
      pend_pl_r <= rd_pl_r;
    end
  end

  // record store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[head_r] <= cmd.ts;
      pay_mem[head_r]  <= cmd.pl;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ts_r <= time_mem[rd_addr];
      rd_pl_r <= pay_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/windowed_trace_ring_buffer.sv =====
// windowed_trace_ring_buffer
// overwriting ring store of 1024 timestamped records with offset, window and
// count queries
// input channel: in_valid / in_stall, one transaction per command; operation
// codes 5 to 7 are taken and dropped
// result channel: out_valid / out_stall, one transaction per result record;
// out_last marks the end of each query's answer
// commands pass an input register and a two-entry command queue before the
// store engine; a query's records pass the read register and a pending
// register before the output register; a count answer follows once every
// stored record has been visited
// appends and clears finish in S_IDLE in the engine: one per cycle sustained while
// no query runs; queries walk the store through S_RD and S_EVAL per visited
// record, limited by the single registered read port; offset reads visit up to
// max_out records, window reads visit records up to the burst limit and counts
// visit every stored record; while a query runs, further commands fill the queue and in_stall rises
// a stalled receiver holds the engine once its one pending record is waiting
// reset (rst_n low, synchronous) empties the store and both channels; record
// contents are not cleared and need no clearing pass
`default_nettype none
module windowed_trace_ring_buffer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_operation,
  input  wire logic [wtrb_pkg::TS_W-1:0]   in_record_timestamp,
  input  wire logic [wtrb_pkg::PL_W-1:0]   in_record_payload,
  input  wire logic [6:0]                  in_max_out,
  input  wire logic [9:0]                  in_start_offset,
  input  wire logic [wtrb_pkg::TS_W-1:0]   in_time_window,
  input  wire logic [9:0]                  in_keep_every,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_valid_res,
  output logic [wtrb_pkg::TS_W-1:0]        out_timestamp,
  output logic [wtrb_pkg::PL_W-1:0]        out_payload,
  output logic [wtrb_pkg::CNT_W-1:0]       out_tally,
  output logic                             out_last
);

  wtrb_pkg::cmd_t      push_cmd;
  wtrb_pkg::cmd_t      pop_cmd;
  wtrb_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;

  wtrb_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_record_timestamp (in_record_timestamp),
    .in_record_payload   (in_record_payload),
    .in_max_out          (in_max_out),
    .in_start_offset     (in_start_offset),
    .in_time_window      (in_time_window),
    .in_keep_every       (in_keep_every),
    .q_status            (q_status),
    .q_push              (q_push),
    .q_cmd               (push_cmd)
  );

  wtrb_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  wtrb_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (pop_cmd),
    .cmd_empty     (q_status.empty),
    .cmd_pop       (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_timestamp (out_timestamp),
    .out_payload   (out_payload),
    .out_tally     (out_tally),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire
